// ===== hdl/scfb_pkg.sv =====
package scfb_pkg;

  // Input opcodes
  typedef enum logic {
    OP_START   = 1'b0,
    OP_PAYLOAD = 1'b1
  } opcode_e;

  // Work handed from front to back
  typedef enum logic {
    CMD_HDR     = 1'b0,
    CMD_PAYLOAD = 1'b1
  } cmd_kind_e;

  localparam logic [7:0] MAGIC_0         = 8'h41;
  localparam logic [7:0] MAGIC_1         = 8'h44;
  localparam logic [7:0] MAGIC_2         = 8'h41;
  localparam logic [7:0] MAGIC_3         = 8'h4D;
  localparam logic [7:0] HDR_BYTE_5      = 8'h00;
  localparam logic [7:0] HDR_BYTE_6      = 8'h01;
  localparam logic [7:0] TOTAL_LEN_BASE  = 8'h10;
  localparam logic [7:0] MODULE_LEN_BASE = 8'h06;

  // Fixed part of the header sum: magic plus bytes 5 and 6
  localparam logic [15:0] HDR_SUM_BASE = 16'(MAGIC_0) + 16'(MAGIC_1) + 16'(MAGIC_2)
                                       + 16'(MAGIC_3) + 16'(HDR_BYTE_5) + 16'(HDR_BYTE_6);

  // Byte positions within a frame
  localparam logic [3:0] POS_FIRST  = 4'd0;
  localparam logic [3:0] POS_BODY   = 4'd13;
  localparam logic [3:0] POS_SUM_LO = 4'd14;
  localparam logic [3:0] POS_SUM_HI = 4'd15;

  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

  typedef struct packed {
    cmd_kind_e   kind;
    logic        last;       // module sum follows this command
    logic [7:0]  seq_number;
    logic [7:0]  total_len;
    logic [15:0] hdr_sum;
    logic [7:0]  module_addr;
    logic [7:0]  module_len;
    logic [7:0]  direction;
    logic [7:0]  command_code;
    logic [7:0]  data_byte;
    logic [15:0] module_sum; // sum including this command's bytes
  } cmd_t;

endpackage

// ===== hdl/scfb_front.sv =====
module scfb_front import scfb_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic       opcode_i,
  input  logic [7:0] seq_number_i,
  input  logic [7:0] module_addr_i,
  input  logic [7:0] direction_i,
  input  logic [7:0] command_code_i,
  input  logic [7:0] payload_len_i,
  input  logic [7:0] data_byte_i,
  input  logic       full_i,
  output logic       push_o,
  output cmd_t       cmd_o
);

  logic        frame_open_q, frame_open_d;
  logic [7:0]  bytes_left_q, bytes_left_d;
  logic [15:0] module_sum_q, module_sum_d;

  logic        is_start;
  logic        accept;
  logic [7:0]  total_len;
  logic [7:0]  module_len;
  logic [15:0] hdr_sum;
  logic [15:0] init_sum;
  logic [7:0]  left_dec;
  logic [15:0] pay_sum;

  assign in_ready_o = !full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign is_start   = (opcode_i == OP_START);

  assign total_len  = payload_len_i + TOTAL_LEN_BASE;
  assign module_len = payload_len_i + MODULE_LEN_BASE;
  assign hdr_sum    = HDR_SUM_BASE + {8'h00, seq_number_i} + {8'h00, total_len};
  assign init_sum   = {8'h00, module_addr_i} + {8'h00, module_len}
                    + {8'h00, direction_i} + {8'h00, command_code_i};
  assign left_dec   = bytes_left_q - 8'd1;
  assign pay_sum    = module_sum_q + {8'h00, data_byte_i};

  // Drop payload bytes that arrive outside an open frame
  assign push_o = accept && (is_start || frame_open_q);

  always_comb begin
    cmd_o.kind         = is_start ? CMD_HDR : CMD_PAYLOAD;
    cmd_o.last         = is_start ? (payload_len_i == 8'd0) : (left_dec == 8'd0);
    cmd_o.seq_number   = seq_number_i;
    cmd_o.total_len    = total_len;
    cmd_o.hdr_sum      = hdr_sum;
    cmd_o.module_addr  = module_addr_i;
    cmd_o.module_len   = module_len;
    cmd_o.direction    = direction_i;
    cmd_o.command_code = command_code_i;
    cmd_o.data_byte    = data_byte_i;
    cmd_o.module_sum   = is_start ? init_sum : pay_sum;
  end

  always_comb begin
    frame_open_d = frame_open_q;
    bytes_left_d = bytes_left_q;
    module_sum_d = module_sum_q;
    if (accept) begin
      if (is_start) begin
        frame_open_d = (payload_len_i != 8'd0);
        bytes_left_d = payload_len_i;
        module_sum_d = init_sum;
      end else if (frame_open_q) begin
        frame_open_d = (left_dec != 8'd0);
        bytes_left_d = left_dec;
        module_sum_d = pay_sum;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_open_q <= 1'b0;
      bytes_left_q <= 8'd0;
      module_sum_q <= 16'd0;
    end else begin
      frame_open_q <= frame_open_d;
      bytes_left_q <= bytes_left_d;
      module_sum_q <= module_sum_d;
    end
  end

endmodule

// ===== hdl/scfb_fifo.sv =====
module scfb_fifo import scfb_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t wdata_i,
  input  logic pop_i,
  output cmd_t head_o,
  output logic empty_o,
  output logic full_o
);

  cmd_t                entry_q [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QUEUE_AW:0]   count_q;

  assign empty_o = (count_q == '0);
  assign full_o  = (count_q == (QUEUE_AW+1)'(QUEUE_DEPTH));
  assign head_o  = entry_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) wr_ptr_q <= wr_ptr_q + QUEUE_AW'(1);
      if (pop_i)  rd_ptr_q <= rd_ptr_q + QUEUE_AW'(1);
      if (push_i && !pop_i) begin
        count_q <= count_q + (QUEUE_AW+1)'(1);
      end else if (pop_i && !push_i) begin
        count_q <= count_q - (QUEUE_AW+1)'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) entry_q[wr_ptr_q] <= wdata_i;
  end

endmodule

// ===== hdl/scfb_back.sv =====
module scfb_back import scfb_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cmd_t       head_i,
  input  logic       empty_i,
  output logic       pop_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_byte_o,
  output logic       frame_end_o
);

  logic       fresh_q;
  logic [3:0] idx_q;
  logic       out_valid_q;
  logic [7:0] out_byte_q;
  logic       frame_end_q;

  logic [3:0] cur_idx;
  logic [3:0] end_idx;
  logic       advance;
  logic [7:0] sel_byte;

  // A fresh command starts at its first byte; payload enters at the body slot
  assign cur_idx = fresh_q ? ((head_i.kind == CMD_PAYLOAD) ? POS_BODY : POS_FIRST) : idx_q;
  assign end_idx = head_i.last ? POS_SUM_HI : POS_BODY;
  assign advance = !empty_i && (!out_valid_q || out_ready_i);
  assign pop_o   = advance && (cur_idx == end_idx);

  always_comb begin
    case (cur_idx)
      4'd0:    sel_byte = MAGIC_0;
      4'd1:    sel_byte = MAGIC_1;
      4'd2:    sel_byte = MAGIC_2;
      4'd3:    sel_byte = MAGIC_3;
      4'd4:    sel_byte = head_i.seq_number;
      4'd5:    sel_byte = HDR_BYTE_5;
      4'd6:    sel_byte = HDR_BYTE_6;
      4'd7:    sel_byte = head_i.total_len;
      4'd8:    sel_byte = head_i.hdr_sum[7:0];
      4'd9:    sel_byte = head_i.hdr_sum[15:8];
      4'd10:   sel_byte = head_i.module_addr;
      4'd11:   sel_byte = head_i.module_len;
      4'd12:   sel_byte = head_i.direction;
      4'd13:   sel_byte = (head_i.kind == CMD_PAYLOAD) ? head_i.data_byte
                                                       : head_i.command_code;
      4'd14:   sel_byte = head_i.module_sum[7:0];
      default: sel_byte = head_i.module_sum[15:8];
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fresh_q     <= 1'b1;
      idx_q       <= POS_FIRST;
      out_valid_q <= 1'b0;
    end else begin
      if (advance) begin
        out_valid_q <= 1'b1;
        fresh_q     <= pop_o;
        idx_q       <= cur_idx + 4'd1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_byte_q  <= sel_byte;
      frame_end_q <= (cur_idx == POS_SUM_HI);
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_byte_o  = out_byte_q;
  assign frame_end_o = frame_end_q;

endmodule

// ===== hdl/spi_command_frame_builder_unit.sv =====
// Command frame serializer. Items are accepted one per cycle while the
// four-entry command queue has room; a start item yields 14 output bytes (16 when
// its payload length is zero) and a payload byte yields 1 (3 when it is the last
// one, carrying the module sum). The output side drives one frame byte per cycle
// while the receiver takes them, so over a frame the rate is set by the output
// register. Payload bytes sent while no frame is open are accepted and discarded.
// A start while a frame is open abandons that frame without its checksum.
// frame_end_o marks the last byte of a frame.
module spi_command_frame_builder_unit import scfb_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic       opcode_i,
  input  logic [7:0] seq_number_i,
  input  logic [7:0] module_addr_i,
  input  logic [7:0] direction_i,
  input  logic [7:0] command_code_i,
  input  logic [7:0] payload_len_i,
  input  logic [7:0] data_byte_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_byte_o,
  output logic       frame_end_o
);

  logic push;
  logic pop;
  logic full;
  logic empty;
  cmd_t push_cmd;
  cmd_t head_cmd;

  scfb_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .opcode_i       (opcode_i),
    .seq_number_i   (seq_number_i),
    .module_addr_i  (module_addr_i),
    .direction_i    (direction_i),
    .command_code_i (command_code_i),
    .payload_len_i  (payload_len_i),
    .data_byte_i    (data_byte_i),
    .full_i         (full),
    .push_o         (push),
    .cmd_o          (push_cmd)
  );

  scfb_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (push_cmd),
    .pop_i   (pop),
    .head_o  (head_cmd),
    .empty_o (empty),
    .full_o  (full)
  );

  scfb_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head_cmd),
    .empty_i     (empty),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_byte_o  (out_byte_o),
    .frame_end_o (frame_end_o)
  );

endmodule

// ===== hdl/scfb_checker.sv =====
module scfb_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_o,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [7:0] out_byte_o,
  input logic       frame_end_o
);

  // A stalled output byte holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_byte_o) && $stable(frame_end_o))
    else $error("output byte changed while stalled");

  // The queue is full only while the output side holds a valid byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o)
    else $error("input blocked while output idle");

  // A frame never ends on two transfers in a row
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && frame_end_o |=> !(out_valid_o && frame_end_o))
    else $error("frame end on consecutive bytes");

  // Input backpressure rises only after an input item was presented
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(in_ready_o) |-> $past(in_valid_i))
    else $error("queue filled without input transfer");

endmodule

bind spi_command_frame_builder_unit scfb_checker u_scfb_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_byte_o  (out_byte_o),
  .frame_end_o (frame_end_o)
);

// ===== verif/scfb_frame_checker.sv =====
module scfb_frame_checker import scfb_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic       in_ready_i,
  input  logic       opcode_i,
  input  logic [7:0] seq_number_i,
  input  logic [7:0] module_addr_i,
  input  logic [7:0] direction_i,
  input  logic [7:0] command_code_i,
  input  logic [7:0] payload_len_i,
  input  logic [7:0] data_byte_i,
  input  logic       out_valid_i,
  input  logic       out_ready_i,
  input  logic [7:0] out_byte_i,
  input  logic       frame_end_i,
  output int         error_count_o,
  output int         pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [7:0] value;
    logic       last;
  } frame_byte_t;

  frame_byte_t frame_bytes_q[$];
  logic        frame_open_q;
  logic [7:0]  bytes_left_q;
  logic [15:0] module_sum_q;
  int          errors = 0;

  assign error_count_o = errors;

  task automatic queue_byte(input logic [7:0] value, input logic last);
    frame_byte_t b;
    b.value = value;
    b.last  = last;
    frame_bytes_q.push_back(b);
  endtask

  task automatic close_frame();
    queue_byte(module_sum_q[7:0], 1'b0);
    queue_byte(module_sum_q[15:8], 1'b1);
    frame_open_q = 1'b0;
    bytes_left_q = '0;
  endtask

  task automatic predict_frame_bytes(input opcode_e op, input logic [7:0] seq,
                                     input logic [7:0] mod, input logic [7:0] dir,
                                     input logic [7:0] cmd, input logic [7:0] plen,
                                     input logic [7:0] data);
    logic [7:0]  hdr [8];
    logic [15:0] hdr_sum;
    logic [7:0]  mod_len;
    if (op == OP_START) begin
      mod_len = MODULE_LEN_BASE + plen;
      hdr = '{MAGIC_0, MAGIC_1, MAGIC_2, MAGIC_3, seq, HDR_BYTE_5, HDR_BYTE_6,
              8'(TOTAL_LEN_BASE + plen)};
      hdr_sum = '0;
      for (int k = 0; k < 8; k++) begin
        hdr_sum += 16'(hdr[k]);
        queue_byte(hdr[k], 1'b0);
      end
      queue_byte(hdr_sum[7:0], 1'b0);
      queue_byte(hdr_sum[15:8], 1'b0);
      queue_byte(mod, 1'b0);
      queue_byte(mod_len, 1'b0);
      queue_byte(dir, 1'b0);
      queue_byte(cmd, 1'b0);
      module_sum_q = 16'(mod) + 16'(mod_len) + 16'(dir) + 16'(cmd);
      frame_open_q = 1'b1;
      bytes_left_q = plen;
      if (plen == 8'd0) close_frame();
    end else if (frame_open_q) begin
      queue_byte(data, 1'b0);
      module_sum_q += 16'(data);
      bytes_left_q -= 8'd1;
      if (bytes_left_q == 8'd0) close_frame();
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    frame_byte_t want;
    if (!rst_ni) begin
      frame_bytes_q.delete();
      frame_open_q = 1'b0;
      bytes_left_q = '0;
      module_sum_q = '0;
      pending_o <= 0;
    end else begin
      // check the output first: a byte can never come from an item taken at this edge
      if (out_valid_i && out_ready_i) begin
        if (frame_bytes_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected byte, expected none, got out_byte %02h frame_end %b",
                   $time, out_byte_i, frame_end_i);
        end else begin
          want = frame_bytes_q.pop_front();
          if (out_byte_i !== want.value) begin
            errors++;
            $display("%0t: out_byte expected %02h, got %02h", $time, want.value, out_byte_i);
          end
          if (frame_end_i !== want.last) begin
            errors++;
            $display("%0t: frame_end expected %b, got %b", $time, want.last, frame_end_i);
          end
        end
      end
      if (in_valid_i && in_ready_i)
        predict_frame_bytes(opcode_e'(opcode_i), seq_number_i, module_addr_i, direction_i,
                            command_code_i, payload_len_i, data_byte_i);
      pending_o <= frame_bytes_q.size();
    end
  end

endmodule

// ===== verif/spi_command_frame_builder_unit_test.sv =====
module spi_command_frame_builder_unit_test;
  import scfb_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_ITEMS = 220;
  localparam int CALM_AFTER   = 180;
  localparam int QUIET_LIMIT  = 3000;
  localparam int HOLD_START   = 300;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 32;

  logic       clk_i          = 1'b0;
  logic       rst_ni         = 1'b0;
  logic       in_valid_i     = 1'b0;
  logic       in_ready_o;
  logic       opcode_i       = OP_START;
  logic [7:0] seq_number_i   = '0;
  logic [7:0] module_addr_i  = '0;
  logic [7:0] direction_i    = '0;
  logic [7:0] command_code_i = '0;
  logic [7:0] payload_len_i  = '0;
  logic [7:0] data_byte_i    = '0;
  logic       out_valid_o;
  logic       out_ready_i    = 1'b0;
  logic [7:0] out_byte_o;
  logic       frame_end_o;

  int error_count;
  int pending_bytes;
  int items_sent = 0;
  int quiet_cycles = 0;
  bit calm = 1'b0;

  always #5 clk_i = ~clk_i;

  spi_command_frame_builder_unit DUT (.*);

  scfb_frame_checker u_checker (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_ready_i    (in_ready_o),
    .opcode_i,
    .seq_number_i,
    .module_addr_i,
    .direction_i,
    .command_code_i,
    .payload_len_i,
    .data_byte_i,
    .out_valid_i   (out_valid_o),
    .out_ready_i,
    .out_byte_i    (out_byte_o),
    .frame_end_i   (frame_end_o),
    .error_count_o (error_count),
    .pending_o     (pending_bytes)
  );

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("spi_command_frame_builder_unit_test: done, errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // receiver: random stalls, a stall-free stretch every third window, one long hold-off
  initial begin
    int cycle;
    cycle = 0;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    out_ready_i <= 1'b1;
    forever begin
      @(posedge clk_i);
      cycle++;
      if (cycle == HOLD_START) begin
        out_ready_i <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end else if (!calm && (cycle / 150) % 3 != 2 && $urandom_range(0, 5) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 11)) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
    end
  end

  task automatic send_item(input opcode_e op, input logic [7:0] seq, input logic [7:0] mod,
                           input logic [7:0] dir, input logic [7:0] cmd,
                           input logic [7:0] plen, input logic [7:0] data);
    if (!calm && (items_sent % 60) < 40 && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    opcode_i       <= op;
    seq_number_i   <= seq;
    module_addr_i  <= mod;
    direction_i    <= dir;
    command_code_i <= cmd;
    payload_len_i  <= plen;
    data_byte_i    <= data;
    do @(posedge clk_i); while (!in_ready_o);
    items_sent++;
  endtask

  task automatic send_start(input logic [7:0] seq, input logic [7:0] mod,
                            input logic [7:0] dir, input logic [7:0] cmd,
                            input logic [7:0] plen);
    send_item(OP_START, seq, mod, dir, cmd, plen, 8'($urandom));
  endtask

  // header fields are don't-care on a payload transfer: fill them with noise
  task automatic send_payload(input logic [7:0] data);
    send_item(OP_PAYLOAD, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
              8'($urandom), data);
  endtask

  initial begin
    int random_items;
    int plen;
    int nbytes;
    int pick;
    bit frame_done;
    random_items = 0;
    frame_done   = 1'b1;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // payload with no frame open is dropped
    send_payload(8'hA5);
    send_start(8'h00, 8'h00, 8'h00, 8'h00, 8'd0);
    send_start(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'd0);
    send_start(8'h12, 8'h80, 8'h01, 8'h7F, 8'd3);
    send_payload(8'h00);
    send_payload(8'hFF);
    send_payload(8'h55);
    send_payload(8'h33);
    // abort a long frame, then finish a one-byte frame
    send_start(8'h01, 8'h02, 8'h03, 8'h04, 8'd239);
    send_payload(8'hC3);
    send_payload(8'h3C);
    send_start(8'hAA, 8'h55, 8'hAA, 8'h55, 8'd1);
    send_payload(8'hAA);
    // out-of-range length wraps both length bytes
    send_start(8'hFE, 8'h7F, 8'h80, 8'hFE, 8'd255);
    send_payload(8'h01);
    send_payload(8'hFE);
    send_payload(8'h80);
    send_start(8'h80, 8'hFF, 8'h00, 8'h01, 8'd0);
    send_start(8'h7F, 8'h01, 8'hFE, 8'h80, 8'd1);
    send_payload(8'hFF);

    while (random_items < RANDOM_ITEMS) begin
      calm = (random_items >= CALM_AFTER);
      if (frame_done && $urandom_range(0, 9) == 0) begin
        send_payload(8'($urandom));
        continue;
      end
      pick = $urandom_range(0, 9);
      if (pick < 7) plen = $urandom_range(0, 6);
      else if (pick < 9) plen = $urandom_range(7, 40);
      else plen = $urandom_range(200, 255);
      // truncate every large frame and a few others so the next start aborts them
      if (pick == 9) nbytes = $urandom_range(0, 6);
      else if (plen > 0 && $urandom_range(0, 9) == 0) nbytes = $urandom_range(0, plen - 1);
      else nbytes = plen;
      send_start(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), 8'(plen));
      random_items++;
      for (int k = 0; k < nbytes && random_items < RANDOM_ITEMS; k++) begin
        send_payload(8'($urandom));
        random_items++;
      end
      frame_done = (nbytes == plen);
    end

    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_bytes != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (error_count == 0)
      $display("spi_command_frame_builder_unit_test: done, clean");
    else
      $display("spi_command_frame_builder_unit_test: done, errors");
    $finish;
  end

endmodule
